// File: rtl/mmul_pkg.sv
// Shared types and constants of the 4x4 fixed-point matrix multiplier.
// Depends on nothing; every other file of the block uses it.
package mmul_pkg;

    // Fixed field widths of the command and result beats
    localparam int WORD_W   = 32;
    localparam int INDEX_W  = 4;
    localparam int OPCODE_W = 2;
    // Column and row selectors, wide enough for the largest supported DIM
    localparam int SEL_W    = 3;
    // Element position as compared inside the cells (up to DIM*DIM - 1)
    localparam int POS_W    = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_PRODUCT = 2'd2
    } opcode_e;

    // Element write broadcast to every cell
    typedef struct packed {
        logic                     wr_a;
        logic                     wr_b;
        logic [INDEX_W-1:0]       index;
        logic signed [WORD_W-1:0] value;
    } wr_req_t;

    // Product element traveling down the chain next to its partial sum
    typedef struct packed {
        logic               valid;
        logic [SEL_W-1:0]   col;
        logic [SEL_W-1:0]   row;
        logic [INDEX_W-1:0] index;
        logic               last;
    } tag_t;

endpackage

// File: rtl/mmul_if.sv
// Valid/ready channels of the matrix multiplier: command beats in, result beats out.
// Depends on mmul_pkg for the field widths.
interface mmul_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [mmul_pkg::OPCODE_W-1:0]     opcode;
    logic [mmul_pkg::INDEX_W-1:0]      element_index;
    logic signed [mmul_pkg::WORD_W-1:0] element_value;

    modport source (output valid, output opcode, output element_index,
                    output element_value, input ready);
    modport sink   (input valid, input opcode, input element_index,
                    input element_value, output ready);
endinterface

interface mmul_res_if;
    logic                              valid;
    logic                              ready;
    logic [mmul_pkg::INDEX_W-1:0]      result_index;
    logic signed [mmul_pkg::WORD_W-1:0] result_value;
    logic                              last_flag;

    modport source (output valid, output result_index, output result_value,
                    output last_flag, input ready);
    modport sink   (input valid, input result_index, input result_value,
                    input last_flag, output ready);
endinterface

// File: rtl/matrix_multiply_4x4.sv
// Top level of the fixed-point matrix multiplier: command decode, element sequencer,
// the chain of DIM multiply-accumulate cells and the output stage.
// Depends on mmul_pkg, mmul_if, mmul_cell and mmul_sat.
//
// Usage:
//   cmd carries one beat per command. OP_WRITE_A / OP_WRITE_B store element_value
//   at element_index (column * DIM + row) of A or B, one beat per cycle while cmd.ready is high, no result.
//   OP_PRODUCT emits DIM*DIM beats of A * B on res in index order, last_flag on the
//   final one. Opcode 3 and writes beyond DIM*DIM are taken and ignored.
//   Results of a product appear on res one per cycle while res is ready.
//   The sequencer feeds one element per advancing cycle into a chain of
//   DIM cells, two register stages per cell (multiply, accumulate), then the result
//   register; cmd.ready returns once the sequencer is done and the chain has drained.
//   While res stalls, the sequencer and every cell hold, nothing is dropped; cmd
//   stays ready for writes once the chain has drained even if a result still waits.
//   Reset clears both matrices to zero and empties the chain.
module matrix_multiply_4x4 #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    mmul_cmd_if.sink   cmd,
    mmul_res_if.source res
);
    import mmul_pkg::*;

    localparam int ACC_W = 2 * WORD_W + $clog2(DIM) + 1;
    localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(DIM - 1);

    logic                    accept;
    logic                    start;
    logic                    advance;
    wr_req_t                 wr;
    logic                    active_reg;
    logic                    active_next;
    logic [SEL_W-1:0]        col_reg;
    logic [SEL_W-1:0]        col_next;
    logic [SEL_W-1:0]        row_reg;
    logic [SEL_W-1:0]        row_next;
    logic [INDEX_W-1:0]      index_reg;
    logic [INDEX_W-1:0]      index_next;
    logic                    last_elem;
    tag_t                    tag_chain [DIM+1];
    logic signed [ACC_W-1:0] sum_chain [DIM+1];
    logic [DIM-1:0]          cell_busy;

    // Take commands only while no product is being sequenced or in the chain
    assign cmd.ready = !active_reg && !(|cell_busy);
    assign accept    = cmd.valid && cmd.ready;
    assign start     = accept && (cmd.opcode == OP_PRODUCT);

    // Decode element writes
    always_comb
    begin
        wr.wr_a  = accept && (cmd.opcode == OP_WRITE_A);
        wr.wr_b  = accept && (cmd.opcode == OP_WRITE_B);
        wr.index = cmd.element_index;
        wr.value = cmd.element_value;
    end

    // Walk the product elements row within column, one per advancing cycle
    assign last_elem = (col_reg == SEL_LAST) && (row_reg == SEL_LAST);

    always_comb
    begin
        active_next = active_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        index_next  = index_reg;
        if (start)
        begin
            active_next = 1'b1;
            col_next    = '0;
            row_next    = '0;
            index_next  = '0;
        end
        else if (active_reg && advance)
        begin
            index_next = index_reg + 1'b1;
            if (last_elem)
            begin
                active_next = 1'b0;
            end
            if (row_reg == SEL_LAST)
            begin
                row_next = '0;
                col_next = col_reg + 1'b1;
            end
            else
            begin
                row_next = row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
            index_reg  <= '0;
        end
        else
        begin
            active_reg <= active_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            index_reg  <= index_next;
        end
    end

    // Head of the chain
    always_comb
    begin
        tag_chain[0].valid = active_reg;
        tag_chain[0].col   = col_reg;
        tag_chain[0].row   = row_reg;
        tag_chain[0].index = index_reg;
        tag_chain[0].last  = last_elem;
    end
    assign sum_chain[0] = '0;

    for (genvar k = 0; k < DIM; k++) begin : g_cell
        mmul_cell #(
            .DIM   (DIM),
            .K     (k),
            .ACC_W (ACC_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .wr      (wr),
            .tag_in  (tag_chain[k]),
            .sum_in  (sum_chain[k]),
            .tag_out (tag_chain[k+1]),
            .sum_out (sum_chain[k+1]),
            .busy    (cell_busy[k])
        );
    end

    mmul_sat #(
        .ACC_W     (ACC_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_sat (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag_chain[DIM]),
        .sum_in  (sum_chain[DIM]),
        .advance (advance),
        .res     (res)
    );

endmodule

// File: rtl/mmul_cell.sv
// One cell of the multiply-accumulate chain: holds column K of A and row K of B,
// adds A[K][row] * B[col][K] to the passing partial sum. Depends on mmul_pkg.
module mmul_cell #(
    parameter int DIM   = 4,
    parameter int K     = 0,
    parameter int ACC_W = 67
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  mmul_pkg::wr_req_t      wr,
    input  mmul_pkg::tag_t         tag_in,
    input  logic signed [ACC_W-1:0] sum_in,
    output mmul_pkg::tag_t         tag_out,
    output logic signed [ACC_W-1:0] sum_out,
    output logic                   busy
);
    import mmul_pkg::*;

    localparam int IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int PROD_W = 2 * WORD_W;

    logic signed [WORD_W-1:0] a_col_reg [DIM];
    logic signed [WORD_W-1:0] b_row_reg [DIM];

    logic signed [WORD_W-1:0] a_sel;
    logic signed [WORD_W-1:0] b_sel;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  sum_d_reg;
    logic signed [ACC_W-1:0]  sum_next;
    logic signed [ACC_W-1:0]  sum_out_reg;
    tag_t                     tag_d_reg;
    tag_t                     tag_out_reg;

    // Store element writes that land in this cell
    for (genvar e = 0; e < DIM; e++) begin : g_entry
        localparam logic [POS_W-1:0] A_POS = POS_W'(K * DIM + e);
        localparam logic [POS_W-1:0] B_POS = POS_W'(e * DIM + K);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_col_reg[e] <= '0;
                b_row_reg[e] <= '0;
            end
            else
            begin
                if (wr.wr_a && (POS_W'(wr.index) == A_POS))
                begin
                    a_col_reg[e] <= wr.value;
                end
                if (wr.wr_b && (POS_W'(wr.index) == B_POS))
                begin
                    b_row_reg[e] <= wr.value;
                end
            end
        end
    end

    // Pick the operands for the arriving tag and multiply
    assign a_sel     = a_col_reg[tag_in.row[IDX_W-1:0]];
    assign b_sel     = b_row_reg[tag_in.col[IDX_W-1:0]];
    assign prod_next = a_sel * b_sel;

    // Add the registered product onto the delayed partial sum
    assign sum_next = sum_d_reg + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // Product stage, then accumulate stage; both hold while the output stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_d_reg   <= '0;
            tag_out_reg <= '0;
        end
        else if (advance)
        begin
            tag_d_reg   <= tag_in;
            tag_out_reg <= tag_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg    <= prod_next;
            sum_d_reg   <= sum_in;
            sum_out_reg <= sum_next;
        end
    end

    assign tag_out = tag_out_reg;
    assign sum_out = sum_out_reg;
    assign busy    = tag_d_reg.valid | tag_out_reg.valid;

endmodule

// File: rtl/mmul_sat.sv
// Output stage: scales the finished sum down by FRAC_BITS, saturates it to a word
// and holds it in the result register. Depends on mmul_pkg and mmul_res_if.
module mmul_sat #(
    parameter int ACC_W     = 67,
    parameter int FRAC_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mmul_pkg::tag_t          tag_in,
    input  logic signed [ACC_W-1:0] sum_in,
    output logic                    advance,
    mmul_res_if.source              res
);
    import mmul_pkg::*;

    localparam int HEAD_W = ACC_W - WORD_W + 1;

    logic signed [ACC_W-1:0]  shifted;
    logic [HEAD_W-1:0]        head;
    logic                     fits;
    logic signed [WORD_W-1:0] value_next;
    logic                     valid_reg;
    logic [INDEX_W-1:0]       index_reg;
    logic signed [WORD_W-1:0] value_reg;
    logic                     last_reg;

    // Floor shift, then clamp anything outside the signed word range
    assign shifted = sum_in >>> FRAC_BITS;
    assign head    = shifted[ACC_W-1:WORD_W-1];
    assign fits    = (&head) | ~(|head);

    always_comb
    begin
        if (fits)
        begin
            value_next = shifted[WORD_W-1:0];
        end
        else if (shifted[ACC_W-1])
        begin
            value_next = {1'b1, {(WORD_W - 1){1'b0}}};
        end
        else
        begin
            value_next = {1'b0, {(WORD_W - 1){1'b1}}};
        end
    end

    // The whole chain moves only when the result register is empty or its result is taken
    assign advance = !valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= tag_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            index_reg <= tag_in.index;
            value_reg <= value_next;
            last_reg  <= tag_in.last;
        end
    end

    assign res.valid        = valid_reg;
    assign res.result_index = index_reg;
    assign res.result_value = value_reg;
    assign res.last_flag    = last_reg;

endmodule
